[src/ctsw_pkg.sv]
// ctsw_pkg: shared constants, codes and types of the contingency table swap walk core
// no dependencies; imported by every module of the block
`default_nettype none

package ctsw_pkg;

	// table geometry and count width
	localparam int MAX_GROUPS     = 8;
	localparam int MAX_CANDIDATES = 8;
	localparam int COUNT_BITS     = 16;

	localparam int GRP_W   = $clog2(MAX_GROUPS);
	localparam int CAND_W  = $clog2(MAX_CANDIDATES);
	localparam int NG_W    = $clog2(MAX_GROUPS + 1);
	localparam int NC_W    = $clog2(MAX_CANDIDATES + 1);
	localparam int CELLS   = MAX_GROUPS * MAX_CANDIDATES;
	localparam int CELL_W  = $clog2(CELLS);

	// fixed field widths of the ports
	localparam int OP_W     = 3;
	localparam int SLOT_W   = 3;
	localparam int IDX_W    = 3;
	localparam int TOTAL_W  = 16;
	localparam int STAT_W   = 2;
	localparam int VALUE_W  = 16;
	localparam int REG_W    = 4;
	localparam int CFG_IDX_W = 1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// input op codes
	localparam logic [OP_W-1:0] OP_LOAD_GROUP = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD_CAND  = 3'd1;
	localparam logic [OP_W-1:0] OP_BUILD      = 3'd2;
	localparam logic [OP_W-1:0] OP_RESTART    = 3'd3;
	localparam logic [OP_W-1:0] OP_STEP       = 3'd4;
	localparam logic [OP_W-1:0] OP_DUMP       = 3'd5;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
	localparam logic [STAT_W-1:0] STAT_SKIP = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_GROUPS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CANDS  = 1'b1;
	localparam logic [REG_W-1:0]     CFG_GROUPS_RST = 4'd8;
	localparam logic [REG_W-1:0]     CFG_CANDS_RST  = 4'd8;

	// classified work kinds
	typedef enum logic [2:0] {
		K_LOAD_G,
		K_LOAD_C,
		K_BUILD,
		K_RESTART,
		K_STEP,
		K_DUMP,
		K_REJECT
	} kind_t;

	// one classified transaction as it waits in the queue
	typedef struct packed {
		kind_t                 kind;
		logic [SLOT_W-1:0]     slot;
		logic [COUNT_BITS-1:0] total;
		logic [GRP_W-1:0]      ga;
		logic [GRP_W-1:0]      gb;
		logic [CAND_W-1:0]     ca;
		logic [CAND_W-1:0]     cb;
		logic [NG_W-1:0]       ng;
		logic [NC_W-1:0]       nc;
	} entry_t;

	// queue status seen by front, back and checks
	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

	// linear cell address of a row and column
	function automatic logic [CELL_W-1:0] cell_addr(input logic [GRP_W-1:0] g,
			input logic [CAND_W-1:0] c);
		cell_addr = CELL_W'(CELL_W'(g) * CELL_W'(MAX_CANDIDATES) + CELL_W'(c));
	endfunction

endpackage

`default_nettype wire

[src/ctsw_front.sv]
// ctsw_front: accepts transactions, holds the configuration registers and classifies
// each op into a queue entry; depends on ctsw_pkg
`default_nettype none

module ctsw_front import ctsw_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [SLOT_W-1:0]    slot,
	input  wire logic [TOTAL_W-1:0]   total,
	input  wire logic [IDX_W-1:0]     group_a,
	input  wire logic [IDX_W-1:0]     group_b,
	input  wire logic [IDX_W-1:0]     cand_a,
	input  wire logic [IDX_W-1:0]     cand_b,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	input  wire queue_stat_t          q_stat,
	output logic                      push,
	output entry_t                    push_entry
);

	logic [REG_W-1:0] groups_cfg_q;
	logic [REG_W-1:0] cands_cfg_q;
	logic [NG_W-1:0]  ng;
	logic [NC_W-1:0]  nc;
	logic             step_bad;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			groups_cfg_q <= CFG_GROUPS_RST;
			cands_cfg_q  <= CFG_CANDS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_GROUPS: groups_cfg_q <= cfg_data;
				CFG_NUM_CANDS:  cands_cfg_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturate row and column counts into the usable range
	always_comb begin
		if (int'(groups_cfg_q) < 2)
			ng = NG_W'(2);
		else if (int'(groups_cfg_q) > MAX_GROUPS)
			ng = NG_W'(MAX_GROUPS);
		else
			ng = NG_W'(groups_cfg_q);
		if (int'(cands_cfg_q) < 2)
			nc = NC_W'(2);
		else if (int'(cands_cfg_q) > MAX_CANDIDATES)
			nc = NC_W'(MAX_CANDIDATES);
		else
			nc = NC_W'(cands_cfg_q);
	end

	// swap indices must lie in use and differ
	assign step_bad = (NG_W'(group_a) >= ng) || (NG_W'(group_b) >= ng) ||
		(NC_W'(cand_a) >= nc) || (NC_W'(cand_b) >= nc) ||
		(group_a == group_b) || (cand_a == cand_b);

	assign busy = q_stat.full;
	assign push = start && !q_stat.full;

	// classify the op
	always_comb begin
		push_entry.slot  = slot;
		push_entry.total = COUNT_BITS'(total);
		push_entry.ga    = GRP_W'(group_a);
		push_entry.gb    = GRP_W'(group_b);
		push_entry.ca    = CAND_W'(cand_a);
		push_entry.cb    = CAND_W'(cand_b);
		push_entry.ng    = ng;
		push_entry.nc    = nc;
		case (op)
			OP_LOAD_GROUP: push_entry.kind = (int'(slot) < MAX_GROUPS) ? K_LOAD_G : K_REJECT;
			OP_LOAD_CAND:  push_entry.kind = (int'(slot) < MAX_CANDIDATES) ? K_LOAD_C : K_REJECT;
			OP_BUILD:      push_entry.kind = K_BUILD;
			OP_RESTART:    push_entry.kind = K_RESTART;
			OP_STEP:       push_entry.kind = step_bad ? K_REJECT : K_STEP;
			OP_DUMP:       push_entry.kind = K_DUMP;
			default:       push_entry.kind = K_REJECT;
		endcase
	end

endmodule

`default_nettype wire

[src/ctsw_queue.sv]
// ctsw_queue: short fifo of classified entries between front and back
// depends on ctsw_pkg
`default_nettype none

module ctsw_queue import ctsw_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire entry_t push_entry,
	input  wire logic   pop,
	output entry_t      head,
	output queue_stat_t q_stat
);

	entry_t            slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head         = slots_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

[src/ctsw_back.sv]
// ctsw_back: carries out queued ops on the totals, start table and working table
// holds both table memories; depends on ctsw_pkg
`default_nettype none

module ctsw_back import ctsw_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire entry_t       head,
	input  wire queue_stat_t  q_stat,
	output logic              pop,
	output logic              done,
	output logic [STAT_W-1:0] status,
	output logic [IDX_W-1:0]  cell_group,
	output logic [IDX_W-1:0]  cell_candidate,
	output logic [VALUE_W-1:0] cell_value,
	output logic              last
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_BUILD = 7'b0000010,
		ST_COPY  = 7'b0000100,
		ST_RD2   = 7'b0001000,
		ST_CHK   = 7'b0010000,
		ST_WR    = 7'b0100000,
		ST_DUMP  = 7'b1000000
	} state_t;

	state_t                state_q;
	entry_t                cur_q;
	logic [GRP_W-1:0]      g_q;
	logic [CAND_W-1:0]     c_q;
	logic [CELL_W:0]       cnt_q;
	logic [1:0]            wr_q;
	logic [COUNT_BITS-1:0] group_tot_q [MAX_GROUPS];
	logic [COUNT_BITS-1:0] cand_tot_q  [MAX_CANDIDATES];
	logic [COUNT_BITS-1:0] gl_q        [MAX_GROUPS];
	logic [COUNT_BITS-1:0] cl_q        [MAX_CANDIDATES];
	logic                  start_built_q;
	logic                  work_loaded_q;
	logic [COUNT_BITS-1:0] vaa_q, vbb_q, vab_q, vba_q;
	logic                  dump_s1;
	logic [GRP_W-1:0]      dg_s1;
	logic [CAND_W-1:0]     dc_s1;
	logic                  dlast_s1;

	// table memories
	logic [COUNT_BITS-1:0] start_mem [CELLS];
	logic [COUNT_BITS-1:0] work_mem  [CELLS];
	logic [COUNT_BITS-1:0] start_rd_q;
	logic [COUNT_BITS-1:0] work_rd_a_q;
	logic [COUNT_BITS-1:0] work_rd_b_q;
	logic                  start_we;
	logic [CELL_W-1:0]     start_wa;
	logic [COUNT_BITS-1:0] start_wd;
	logic [CELL_W-1:0]     start_ra;
	logic                  work_we;
	logic [CELL_W-1:0]     work_wa;
	logic [COUNT_BITS-1:0] work_wd;
	logic [CELL_W-1:0]     work_ra_a;
	logic [CELL_W-1:0]     work_ra_b;

	logic [COUNT_BITS-1:0] start_val, wa_val, wb_val;
	logic [COUNT_BITS-1:0] gsel, csel, bmin;
	logic                  cell_in;
	logic                  skip;
	logic                  dump_end;

	// tables read as zero until first fully written
	assign start_val = start_built_q ? start_rd_q : '0;
	assign wa_val    = work_loaded_q ? work_rd_a_q : '0;
	assign wb_val    = work_loaded_q ? work_rd_b_q : '0;

	// northwest-corner cell value
	assign gsel    = gl_q[g_q];
	assign csel    = cl_q[c_q];
	assign bmin    = (gsel < csel) ? gsel : csel;
	assign cell_in = (NG_W'(g_q) < cur_q.ng) && (NC_W'(c_q) < cur_q.nc);

	// swap move is skipped on an empty source or a saturated target
	assign skip = (vaa_q == '0) || (vbb_q == '0) || (wa_val == COUNT_MAX) ||
		(wb_val == COUNT_MAX);

	assign dump_end = (NG_W'(g_q) == cur_q.ng - 1'b1) && (NC_W'(c_q) == cur_q.nc - 1'b1);

	assign pop = (state_q == ST_IDLE) && !q_stat.empty && !dump_s1;

	always_ff @(posedge clk) begin
		if (start_we)
			start_mem[start_wa] <= start_wd;
		start_rd_q <= start_mem[start_ra];
	end

	always_ff @(posedge clk) begin
		if (work_we)
			work_mem[work_wa] <= work_wd;
		work_rd_a_q <= work_mem[work_ra_a];
		work_rd_b_q <= work_mem[work_ra_b];
	end

	// memory addresses and writes per state
	always_comb begin
		start_we  = 1'b0;
		start_wa  = cell_addr(g_q, c_q);
		start_wd  = cell_in ? bmin : '0;
		start_ra  = cnt_q[CELL_W-1:0];
		work_we   = 1'b0;
		work_wa   = cell_addr(cur_q.ga, cur_q.ca);
		work_wd   = vaa_q - 1'b1;
		work_ra_a = cell_addr(head.ga, head.ca);
		work_ra_b = cell_addr(head.gb, head.cb);
		case (state_q)
			ST_BUILD: start_we = 1'b1;
			ST_COPY: begin
				work_we = (cnt_q != '0);
				work_wa = CELL_W'(cnt_q - 1'b1);
				work_wd = start_val;
			end
			ST_RD2: begin
				work_ra_a = cell_addr(cur_q.ga, cur_q.cb);
				work_ra_b = cell_addr(cur_q.gb, cur_q.ca);
			end
			ST_CHK: work_we = !skip;
			ST_WR: begin
				work_we = 1'b1;
				if (wr_q == 2'd0) begin
					work_wa = cell_addr(cur_q.gb, cur_q.cb);
					work_wd = vbb_q - 1'b1;
				end else if (wr_q == 2'd1) begin
					work_wa = cell_addr(cur_q.ga, cur_q.cb);
					work_wd = vab_q + 1'b1;
				end else begin
					work_wa = cell_addr(cur_q.gb, cur_q.ca);
					work_wd = vba_q + 1'b1;
				end
			end
			ST_DUMP: work_ra_a = cell_addr(g_q, c_q);
			default: ;
		endcase
	end

	// sequencer, totals and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cur_q          <= '0;
			g_q            <= '0;
			c_q            <= '0;
			cnt_q          <= '0;
			wr_q           <= '0;
			start_built_q  <= 1'b0;
			work_loaded_q  <= 1'b0;
			vaa_q          <= '0;
			vbb_q          <= '0;
			vab_q          <= '0;
			vba_q          <= '0;
			dump_s1        <= 1'b0;
			dg_s1          <= '0;
			dc_s1          <= '0;
			dlast_s1       <= 1'b0;
			done           <= 1'b0;
			status         <= STAT_DONE;
			cell_group     <= '0;
			cell_candidate <= '0;
			cell_value     <= '0;
			last           <= 1'b0;
			for (int i = 0; i < MAX_GROUPS; i++) begin
				group_tot_q[i] <= '0;
				gl_q[i]        <= '0;
			end
			for (int i = 0; i < MAX_CANDIDATES; i++) begin
				cand_tot_q[i] <= '0;
				cl_q[i]       <= '0;
			end
		end else begin
			done           <= 1'b0;
			dump_s1        <= 1'b0;
			status         <= STAT_DONE;
			cell_group     <= '0;
			cell_candidate <= '0;
			cell_value     <= '0;
			last           <= 1'b1;

			// dumped cell leaves from the registered memory read, tracked by dump_s1
			if (dump_s1) begin
				done           <= 1'b1;
				cell_group     <= IDX_W'(dg_s1);
				cell_candidate <= IDX_W'(dc_s1);
				cell_value     <= VALUE_W'(wa_val);
				last           <= dlast_s1;
			end

			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cur_q <= head;
						g_q   <= '0;
						c_q   <= '0;
						cnt_q <= '0;
						case (head.kind)
							K_LOAD_G: begin
								group_tot_q[GRP_W'(head.slot)] <= head.total;
								done <= 1'b1;
							end
							K_LOAD_C: begin
								cand_tot_q[CAND_W'(head.slot)] <= head.total;
								done <= 1'b1;
							end
							K_BUILD: begin
								gl_q    <= group_tot_q;
								cl_q    <= cand_tot_q;
								state_q <= ST_BUILD;
							end
							K_RESTART: state_q <= ST_COPY;
							K_STEP:    state_q <= ST_RD2;
							K_DUMP:    state_q <= ST_DUMP;
							default: begin
								done   <= 1'b1;
								status <= STAT_BAD;
							end
						endcase
					end
				end
				ST_BUILD: begin
					if (cell_in) begin
						gl_q[g_q] <= gsel - bmin;
						cl_q[c_q] <= csel - bmin;
					end
					if (c_q == CAND_W'(MAX_CANDIDATES - 1)) begin
						c_q <= '0;
						g_q <= g_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
					end
					if (c_q == CAND_W'(MAX_CANDIDATES - 1) && g_q == GRP_W'(MAX_GROUPS - 1)) begin
						start_built_q <= 1'b1;
						done          <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				ST_COPY: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (CELL_W + 1)'(CELLS)) begin
						work_loaded_q <= 1'b1;
						done          <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				ST_RD2: begin
					vaa_q   <= wa_val;
					vbb_q   <= wb_val;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					done <= 1'b1;
					if (skip) begin
						status  <= STAT_SKIP;
						state_q <= ST_IDLE;
					end else begin
						vab_q   <= wa_val;
						vba_q   <= wb_val;
						wr_q    <= '0;
						state_q <= ST_WR;
					end
				end
				ST_WR: begin
					wr_q <= wr_q + 1'b1;
					if (wr_q == 2'd2)
						state_q <= ST_IDLE;
				end
				ST_DUMP: begin
					dump_s1  <= 1'b1;
					dg_s1    <= g_q;
					dc_s1    <= c_q;
					dlast_s1 <= dump_end;
					if (NC_W'(c_q) == cur_q.nc - 1'b1) begin
						c_q <= '0;
						g_q <= g_q + 1'b1;
					end else begin
						c_q <= c_q + 1'b1;
					end
					if (dump_end)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[src/contingency_table_swap_walk_core.sv]
// contingency_table_swap_walk_core: top level of the swap walk block
// ties front, queue and back together; depends on ctsw_pkg and the ctsw_* modules
//
// usage: a transaction is taken at a rising edge where start is high and busy is
// low; op selects load group total, load candidate total, build, restart, step or
// dump. busy rises only when the two-entry queue in front of the executor is full.
// each result shows on status, cell_group, cell_candidate, cell_value and last for
// one cycle while done is high; the receiver cannot stall, so results just leave.
// the executor takes a new transaction from the queue only when idle. a load or
// rejected op finishes at the pop; a step reads its four cells, gives its result,
// then makes three more single-port writes of the working table (none when skipped);
// build walks all 64 cells northwest-corner at one cell per cycle; restart copies
// all 64 cells, each written from the registered start table read; dump gives one
// cell per cycle over the ng*nc cells in use, row by row. a transaction can also
// wait in the queue behind earlier ones.
// reset clears totals, counts and status; both tables read as zero until first
// built or restarted, so no clearing pass is needed. the user must write the
// configuration registers num_groups and num_candidates (reset 8) through cfg_we
// only while idle; the block itself does not enforce it.
`default_nettype none

module contingency_table_swap_walk_core import ctsw_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [SLOT_W-1:0]    slot,
	input  wire logic [TOTAL_W-1:0]   total,
	input  wire logic [IDX_W-1:0]     group_a,
	input  wire logic [IDX_W-1:0]     group_b,
	input  wire logic [IDX_W-1:0]     cand_a,
	input  wire logic [IDX_W-1:0]     cand_b,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	output logic                      done,
	output logic [STAT_W-1:0]         status,
	output logic [IDX_W-1:0]          cell_group,
	output logic [IDX_W-1:0]          cell_candidate,
	output logic [VALUE_W-1:0]        cell_value,
	output logic                      last
);

	queue_stat_t q_stat;
	entry_t      push_entry;
	entry_t      head;
	logic        push;
	logic        pop;

	// accept and classify
	ctsw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.slot       (slot),
		.total      (total),
		.group_a    (group_a),
		.group_b    (group_b),
		.cand_a     (cand_a),
		.cand_b     (cand_b),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// decoupling queue
	ctsw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// executor with table memories
	ctsw_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_stat         (q_stat),
		.pop            (pop),
		.done           (done),
		.status         (status),
		.cell_group     (cell_group),
		.cell_candidate (cell_candidate),
		.cell_value     (cell_value),
		.last           (last)
	);

`ifndef ASSERT_OFF
	// queue never reports full and empty together
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue full and empty at once");

	// no transaction is pushed into a full queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

	// rejected transactions give a single result with empty cell fields
	a_bad_plain: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_BAD |-> last && cell_value == '0 && cell_group == '0)
		else $error("bad status result carries cell data");

	// a skipped move gives a single result with no cell value
	a_skip_single: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_SKIP |-> last && cell_value == '0)
		else $error("skip result not a single plain result");
`endif

endmodule

`default_nettype wire

[tb/sv/ctsw_table_checker.sv]
// ctsw_table_checker: predicts every result of the swap walk core and compares it
// depends on ctsw_pkg; watches the transaction, configuration and result ports
`timescale 1ns / 100ps

module ctsw_table_checker import ctsw_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic                 busy,
	input  wire logic [OP_W-1:0]      op,
	input  wire logic [SLOT_W-1:0]    slot,
	input  wire logic [TOTAL_W-1:0]   total,
	input  wire logic [IDX_W-1:0]     group_a,
	input  wire logic [IDX_W-1:0]     group_b,
	input  wire logic [IDX_W-1:0]     cand_a,
	input  wire logic [IDX_W-1:0]     cand_b,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_data,
	input  wire logic                 done,
	input  wire logic [STAT_W-1:0]    status,
	input  wire logic [IDX_W-1:0]     cell_group,
	input  wire logic [IDX_W-1:0]     cell_candidate,
	input  wire logic [VALUE_W-1:0]   cell_value,
	input  wire logic                 last,
	output int                        fail_count,
	output int                        pending
);

	// one expected result
	typedef struct packed {
		logic [STAT_W-1:0]  st;
		logic [IDX_W-1:0]   grp;
		logic [IDX_W-1:0]   cand;
		logic [VALUE_W-1:0] value;
		logic               fin;
	} cell_result_t;

	cell_result_t expected_cells[$];

	// shadow of the block state
	logic [REG_W-1:0]      rows_reg;
	logic [REG_W-1:0]      cols_reg;
	logic [COUNT_BITS-1:0] group_total [MAX_GROUPS];
	logic [COUNT_BITS-1:0] cand_total [MAX_CANDIDATES];
	logic [COUNT_BITS-1:0] start_cells [CELLS];
	logic [COUNT_BITS-1:0] walk_cells [CELLS];

	// rows or columns in use, saturated into 2..hi
	function automatic int clamp_size(input logic [REG_W-1:0] v, input int hi);
		if (int'(v) < 2)
			return 2;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	task automatic note_mismatch(input string what, input int unsigned want,
			input int unsigned got);
		fail_count++;
		$display("%0t %s mismatch: expected %0h actual %0h", $time, what, want, got);
	endtask

	// expected results of one accepted transaction
	task automatic predict_table_op(input logic [OP_W-1:0] code,
			input logic [SLOT_W-1:0] s, input logic [TOTAL_W-1:0] t,
			input logic [IDX_W-1:0] ga, input logic [IDX_W-1:0] gb,
			input logic [IDX_W-1:0] ca, input logic [IDX_W-1:0] cb);
		int rows, cols, g, c, k, n, aa, bb, ab, ba;
		logic [STAT_W-1:0] st;
		logic [COUNT_BITS-1:0] row_rem [MAX_GROUPS];
		logic [COUNT_BITS-1:0] col_rem [MAX_CANDIDATES];
		logic [COUNT_BITS-1:0] m;
		cell_result_t r;
		rows = clamp_size(rows_reg, MAX_GROUPS);
		cols = clamp_size(cols_reg, MAX_CANDIDATES);
		st = STAT_DONE;
		case (code)
			OP_LOAD_GROUP: begin
				if (int'(s) < MAX_GROUPS)
					group_total[s] = t;
				else
					st = STAT_BAD;
			end
			OP_LOAD_CAND: begin
				if (int'(s) < MAX_CANDIDATES)
					cand_total[s] = t;
				else
					st = STAT_BAD;
			end
			OP_BUILD: begin
				// northwest corner walk on copies of the totals
				for (g = 0; g < MAX_GROUPS; g++)
					row_rem[g] = group_total[g];
				for (c = 0; c < MAX_CANDIDATES; c++)
					col_rem[c] = cand_total[c];
				for (k = 0; k < CELLS; k++)
					start_cells[k] = '0;
				for (g = 0; g < rows; g++) begin
					for (c = 0; c < cols; c++) begin
						m = (row_rem[g] < col_rem[c]) ? row_rem[g] : col_rem[c];
						start_cells[g * MAX_CANDIDATES + c] = m;
						row_rem[g] -= m;
						col_rem[c] -= m;
					end
				end
			end
			OP_RESTART: begin
				for (k = 0; k < CELLS; k++)
					walk_cells[k] = start_cells[k];
			end
			OP_STEP: begin
				if (int'(ga) >= rows || int'(gb) >= rows || int'(ca) >= cols
						|| int'(cb) >= cols || ga == gb || ca == cb) begin
					st = STAT_BAD;
				end else begin
					aa = int'(ga) * MAX_CANDIDATES + int'(ca);
					bb = int'(gb) * MAX_CANDIDATES + int'(cb);
					ab = int'(ga) * MAX_CANDIDATES + int'(cb);
					ba = int'(gb) * MAX_CANDIDATES + int'(ca);
					// skip on an empty source cell or a saturated target cell
					if (walk_cells[aa] == '0 || walk_cells[bb] == '0
							|| walk_cells[ab] == COUNT_MAX || walk_cells[ba] == COUNT_MAX) begin
						st = STAT_SKIP;
					end else begin
						walk_cells[aa] -= 1'b1;
						walk_cells[bb] -= 1'b1;
						walk_cells[ab] += 1'b1;
						walk_cells[ba] += 1'b1;
					end
				end
			end
			OP_DUMP: ;
			default: st = STAT_BAD;
		endcase
		if (code == OP_DUMP) begin
			// row by row over the rows and columns in use
			n = rows * cols;
			k = 0;
			for (g = 0; g < rows; g++) begin
				for (c = 0; c < cols; c++) begin
					r.st    = STAT_DONE;
					r.grp   = IDX_W'(g);
					r.cand  = IDX_W'(c);
					r.value = walk_cells[g * MAX_CANDIDATES + c];
					r.fin   = (k == n - 1);
					expected_cells.push_back(r);
					k++;
				end
			end
		end else begin
			r.st    = st;
			r.grp   = '0;
			r.cand  = '0;
			r.value = '0;
			r.fin   = 1'b1;
			expected_cells.push_back(r);
		end
	endtask

	// compare one result with the oldest expectation
	task automatic check_result();
		cell_result_t want;
		if (expected_cells.size() == 0) begin
			fail_count++;
			$display("%0t result with nothing expected: expected none actual %0h/%0h/%0h/%0h/%0h",
				$time, status, cell_group, cell_candidate, cell_value, last);
		end else begin
			want = expected_cells.pop_front();
			if (status !== want.st)
				note_mismatch("status", want.st, status);
			if (cell_group !== want.grp)
				note_mismatch("cell_group", want.grp, cell_group);
			if (cell_candidate !== want.cand)
				note_mismatch("cell_candidate", want.cand, cell_candidate);
			if (cell_value !== want.value)
				note_mismatch("cell_value", want.value, cell_value);
			if (last !== want.fin)
				note_mismatch("last", want.fin, last);
		end
	endtask

	// sample every channel at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg = CFG_GROUPS_RST;
			cols_reg = CFG_CANDS_RST;
			foreach (group_total[i])
				group_total[i] = '0;
			foreach (cand_total[i])
				cand_total[i] = '0;
			foreach (start_cells[i])
				start_cells[i] = '0;
			foreach (walk_cells[i])
				walk_cells[i] = '0;
			expected_cells.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_NUM_GROUPS)
					rows_reg = cfg_data;
				else if (cfg_index == CFG_NUM_CANDS)
					cols_reg = cfg_data;
			end
			if (done)
				check_result();
			if (start && !busy)
				predict_table_op(op, slot, total, group_a, group_b, cand_a, cand_b);
			pending <= expected_cells.size();
		end
	end

endmodule

[tb/sv/tb.sv]
// tb: stimulus and verdict for contingency_table_swap_walk_core
// depends on ctsw_pkg, the core and ctsw_table_checker
`timescale 1ns / 100ps

module tb;
	import ctsw_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int PHASES       = 6;
	localparam int MIXED_ITEMS  = 15;
	localparam int DRAIN_CYCLES = 100;

	// register settings per phase; the last phase draws its own
	localparam logic [REG_W-1:0] PHASE_ROWS [PHASES] = '{4'd2, 4'd15, 4'd0, 4'd8, 4'd1, 4'd8};
	localparam logic [REG_W-1:0] PHASE_COLS [PHASES] = '{4'd2, 4'd0, 4'd15, 4'd8, 4'd9, 4'd8};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [OP_W-1:0]      op = '0;
	logic [SLOT_W-1:0]    slot = '0;
	logic [TOTAL_W-1:0]   total = '0;
	logic [IDX_W-1:0]     group_a = '0;
	logic [IDX_W-1:0]     group_b = '0;
	logic [IDX_W-1:0]     cand_a = '0;
	logic [IDX_W-1:0]     cand_b = '0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_data = '0;
	logic                 busy;
	logic                 done;
	logic [STAT_W-1:0]    status;
	logic [IDX_W-1:0]     cell_group;
	logic [IDX_W-1:0]     cell_candidate;
	logic [VALUE_W-1:0]   cell_value;
	logic                 last;
	int                   fail_count;
	int                   pending;

	int idle_pct;
	int rows_used;
	int cols_used;

	contingency_table_swap_walk_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .slot(slot), .total(total),
		.group_a(group_a), .group_b(group_b), .cand_a(cand_a), .cand_b(cand_b),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .status(status), .cell_group(cell_group),
		.cell_candidate(cell_candidate), .cell_value(cell_value), .last(last)
	);

	ctsw_table_checker table_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op(op), .slot(slot), .total(total),
		.group_a(group_a), .group_b(group_b), .cand_a(cand_a), .cand_b(cand_b),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .status(status), .cell_group(cell_group),
		.cell_candidate(cell_candidate), .cell_value(cell_value), .last(last),
		.fail_count(fail_count), .pending(pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int used_size(input logic [REG_W-1:0] v, input int hi);
		if (int'(v) < 2)
			return 2;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic logic [IDX_W-1:0] any_index();
		return IDX_W'($urandom_range(0, 7));
	endfunction

	// mostly small totals so that steps find nonzero cells
	function automatic logic [TOTAL_W-1:0] random_total();
		if ($urandom_range(0, 7) == 0)
			return TOTAL_W'($urandom_range(0, 65535));
		return TOTAL_W'($urandom_range(0, 15));
	endfunction

	// offer one transaction after random idle cycles, hold it until taken
	task automatic issue(input logic [OP_W-1:0] code, input logic [SLOT_W-1:0] s,
			input logic [TOTAL_W-1:0] t, input logic [IDX_W-1:0] ga,
			input logic [IDX_W-1:0] gb, input logic [IDX_W-1:0] ca,
			input logic [IDX_W-1:0] cb);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start   <= 1'b1;
		op      <= code;
		slot    <= s;
		total   <= t;
		group_a <= ga;
		group_b <= gb;
		cand_a  <= ca;
		cand_b  <= cb;
		do @(posedge clk); while (busy);
	endtask

	// a swap move inside the rows and columns in use, distinct indices
	task automatic issue_walk_step();
		int ga, gb, ca, cb;
		ga = $urandom_range(0, rows_used - 1);
		gb = (ga + $urandom_range(1, rows_used - 1)) % rows_used;
		ca = $urandom_range(0, cols_used - 1);
		cb = (ca + $urandom_range(1, cols_used - 1)) % cols_used;
		issue(OP_STEP, SLOT_W'($urandom_range(0, 7)), TOTAL_W'($urandom_range(0, 65535)),
			IDX_W'(ga), IDX_W'(gb), IDX_W'(ca), IDX_W'(cb));
	endtask

	task automatic issue_mixed();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			issue(OP_LOAD_GROUP, SLOT_W'($urandom_range(0, 7)), random_total(),
				any_index(), any_index(), any_index(), any_index());
		else if (pick < 12)
			issue(OP_LOAD_CAND, SLOT_W'($urandom_range(0, 7)), random_total(),
				any_index(), any_index(), any_index(), any_index());
		else if (pick < 17)
			issue(OP_BUILD, SLOT_W'($urandom_range(0, 7)), random_total(),
				any_index(), any_index(), any_index(), any_index());
		else if (pick < 22)
			issue(OP_RESTART, SLOT_W'($urandom_range(0, 7)), random_total(),
				any_index(), any_index(), any_index(), any_index());
		else if (pick < 30)
			issue(OP_DUMP, SLOT_W'($urandom_range(0, 7)), random_total(),
				any_index(), any_index(), any_index(), any_index());
		else if (pick < 36)
			issue(OP_W'($urandom_range(0, 7)), SLOT_W'($urandom_range(0, 7)),
				TOTAL_W'($urandom_range(0, 65535)),
				any_index(), any_index(), any_index(), any_index());
		else if (pick < 42)
			issue(OP_STEP, SLOT_W'($urandom_range(0, 7)), random_total(),
				any_index(), any_index(), any_index(), any_index());
		else
			issue_walk_step();
	endtask

	// drain, wait out trailing table writes, then write both registers
	task automatic settle_and_configure(input logic [REG_W-1:0] g_reg,
			input logic [REG_W-1:0] c_reg);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_NUM_GROUPS;
		cfg_data  <= g_reg;
		@(posedge clk);
		cfg_index <= CFG_NUM_CANDS;
		cfg_data  <= c_reg;
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_used = used_size(g_reg, MAX_GROUPS);
		cols_used = used_size(c_reg, MAX_CANDIDATES);
	endtask

	initial begin
		int p, i;
		logic [REG_W-1:0] g_reg, c_reg;
		idle_pct  = 23;
		rows_used = used_size(CFG_GROUPS_RST, MAX_GROUPS);
		cols_used = used_size(CFG_CANDS_RST, MAX_CANDIDATES);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, unused ops, skips and bad indices, extreme totals
		issue(OP_DUMP, 3'd0, 16'd0, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_SPARE_LO, 3'd7, 16'hFFFF, 3'd7, 3'd7, 3'd7, 3'd7);
		issue(OP_SPARE_HI, 3'd0, 16'd0, 3'd0, 3'd1, 3'd0, 3'd1);
		issue(OP_STEP, 3'd0, 16'd0, 3'd0, 3'd1, 3'd0, 3'd1);
		issue(OP_STEP, 3'd0, 16'd0, 3'd2, 3'd2, 3'd0, 3'd1);
		issue(OP_STEP, 3'd0, 16'd0, 3'd0, 3'd1, 3'd3, 3'd3);
		issue(OP_LOAD_GROUP, 3'd0, 16'hFFFF, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_LOAD_CAND, 3'd0, 16'hFFFF, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_LOAD_GROUP, 3'd7, 16'd12, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_LOAD_CAND, 3'd7, 16'd5, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_LOAD_GROUP, 3'd1, 16'd3, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_LOAD_CAND, 3'd1, 16'd4, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_BUILD, 3'd0, 16'd0, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_RESTART, 3'd0, 16'd0, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_DUMP, 3'd0, 16'd0, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_STEP, 3'd0, 16'd0, 3'd0, 3'd7, 3'd0, 3'd7);
		issue(OP_STEP, 3'd0, 16'd0, 3'd7, 3'd1, 3'd1, 3'd7);
		issue(OP_STEP, 3'd0, 16'd0, 3'd7, 3'd0, 3'd7, 3'd0);
		issue(OP_DUMP, 3'd0, 16'd0, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_RESTART, 3'd0, 16'd0, 3'd0, 3'd0, 3'd0, 3'd0);
		issue(OP_DUMP, 3'd0, 16'd0, 3'd0, 3'd0, 3'd0, 3'd0);

		// random phases: load all totals, build, restart, then a mixed walk
		for (p = 0; p < PHASES; p++) begin
			idle_pct = (p < 2) ? 23 : ((p < 4) ? 77 : 0);
			g_reg = PHASE_ROWS[p];
			c_reg = PHASE_COLS[p];
			if (p == PHASES - 1) begin
				g_reg = REG_W'($urandom_range(0, 15));
				c_reg = REG_W'($urandom_range(0, 15));
			end
			settle_and_configure(g_reg, c_reg);
			for (i = 0; i < MAX_GROUPS; i++)
				issue(OP_LOAD_GROUP, SLOT_W'(i), random_total(),
					any_index(), any_index(), any_index(), any_index());
			for (i = 0; i < MAX_CANDIDATES; i++)
				issue(OP_LOAD_CAND, SLOT_W'(i), random_total(),
					any_index(), any_index(), any_index(), any_index());
			issue(OP_BUILD, SLOT_W'($urandom_range(0, 7)), random_total(),
				any_index(), any_index(), any_index(), any_index());
			issue(OP_RESTART, SLOT_W'($urandom_range(0, 7)), random_total(),
				any_index(), any_index(), any_index(), any_index());
			for (i = 0; i < MIXED_ITEMS; i++)
				issue_mixed();
		end

		// drain and give the verdict
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
